// ===== rtl/png_scanline_unfilter_assert.svh =====
// assertion macros for the scanline unfilter block
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psu check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psu check failed: next-cycle implication");

`endif

// ===== rtl/psu_pkg.sv =====
// shared types, codes and helper functions of the scanline unfilter
package psu_pkg;

  localparam int COL_W      = 16;
  localparam int ROW_W      = 16;
  localparam int RB_W       = 14;
  localparam int RB_EXT_W   = 17;
  localparam int BPP_W      = 3;
  localparam int MAX_BPP    = 4;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 2'd2;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;
  localparam logic [7:0] FLT_LAST_CODE = 8'd4;

  // one classified byte on its way from the front end to the back end
  typedef struct packed {
    logic              is_err;
    logic [2:0]        filter;
    logic [7:0]        raw;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              left_ok;
    logic              row_nz;
    logic              row_end;
    logic              image_end;
  } item_t;

  typedef struct packed {
    logic push;
    logic err;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // residue mod 3 of a 16-bit value: base-4 digits each weigh 1 mod 3
  function automatic logic [1:0] mod3(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    int i;
    s = '0;
    for (i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    return v[9] ? 10'(-v) : 10'(v);
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] sa, sb, sc;
    logic [9:0] da, db, dc;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    da = abs10(sb - sc);
    db = abs10(sa - sc);
    dc = abs10(sa + sb - sc - sc);
    if (da <= db && da <= dc) begin
      return a;
    end else if (db <= dc) begin
      return b;
    end
    return c;
  endfunction

endpackage

// ===== rtl/psu_front.sv =====
// front end: config registers, row/column tracking and byte classification
module psu_front #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_raw_byte,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  psu_pkg::fifo_stat_t                fifo_stat,
  output psu_pkg::item_t                     push_item,
  output psu_pkg::front_stat_t               stat
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam logic [psu_pkg::RB_EXT_W-1:0] MAX_RB = psu_pkg::RB_EXT_W'(MAX_ROW_BYTES);
  localparam logic [psu_pkg::RB_EXT_W-1:0] ONE_EXT = psu_pkg::RB_EXT_W'(1);

  logic [psu_pkg::RB_W-1:0]  row_bytes_r;
  logic [psu_pkg::ROW_W-1:0] image_rows_r;
  logic [psu_pkg::BPP_W-1:0] bpp_r;

  logic [CW-1:0]             col_r, col_nxt;
  logic [psu_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [2:0]                filt_r, filt_nxt;
  logic                      expect_r, expect_nxt;
  logic                      err_r, err_nxt;

  logic [psu_pkg::RB_EXT_W-1:0] eff_rb, eff_rows, rb_ext, col_ext, col_cl;
  logic [psu_pkg::BPP_W-1:0]    eff_bpp;
  logic [psu_pkg::COL_W-1:0]    col16;
  logic [psu_pkg::SLOT_W-1:0]   slot;
  logic                         row_end, image_end, accept, push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r  <= psu_pkg::RB_W'(1);
      image_rows_r <= psu_pkg::ROW_W'(1);
      bpp_r        <= psu_pkg::BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psu_pkg::REG_ROW_BYTES:  row_bytes_r  <= cfg_data[psu_pkg::RB_W-1:0];
        psu_pkg::REG_IMAGE_ROWS: image_rows_r <= cfg_data[psu_pkg::ROW_W-1:0];
        psu_pkg::REG_BPP:        bpp_r        <= cfg_data[psu_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their legal ranges
  always_comb begin
    rb_ext = psu_pkg::RB_EXT_W'(row_bytes_r);
    if (rb_ext == '0) begin
      eff_rb = ONE_EXT;
    end else if (rb_ext > MAX_RB) begin
      eff_rb = MAX_RB;
    end else begin
      eff_rb = rb_ext;
    end
    eff_rows = (image_rows_r == '0) ? ONE_EXT : psu_pkg::RB_EXT_W'(image_rows_r);
    if (bpp_r == '0) begin
      eff_bpp = psu_pkg::BPP_W'(1);
    end else if (bpp_r > psu_pkg::BPP_W'(psu_pkg::MAX_BPP)) begin
      eff_bpp = psu_pkg::BPP_W'(psu_pkg::MAX_BPP);
    end else begin
      eff_bpp = bpp_r;
    end
  end

  // column clamps when row_bytes shrank mid-row
  always_comb begin
    col_ext   = psu_pkg::RB_EXT_W'(col_r);
    col_cl    = (col_ext >= eff_rb) ? (eff_rb - ONE_EXT) : col_ext;
    col16     = col_cl[psu_pkg::COL_W-1:0];
    row_end   = (col_cl + ONE_EXT) >= eff_rb;
    image_end = row_end && ((psu_pkg::RB_EXT_W'(row_r) + ONE_EXT) >= eff_rows);
    case (eff_bpp)
      3'd1:    slot = '0;
      3'd2:    slot = {1'b0, col16[0]};
      3'd3:    slot = psu_pkg::mod3(col16);
      default: slot = col16[1:0];
    endcase
  end

  assign in_stall = !err_r && fifo_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    filt_nxt   = filt_r;
    expect_nxt = expect_r;
    err_nxt    = err_r;
    push       = 1'b0;

    push_item.is_err    = 1'b0;
    push_item.filter    = filt_r;
    push_item.raw       = in_raw_byte;
    push_item.col       = col16;
    push_item.slot      = slot;
    push_item.left_ok   = col_cl >= psu_pkg::RB_EXT_W'(eff_bpp);
    push_item.row_nz    = row_r != '0;
    push_item.row_end   = row_end;
    push_item.image_end = image_end;

    if (accept && !err_r) begin
      if (expect_r) begin
        if (in_raw_byte > psu_pkg::FLT_LAST_CODE) begin
          err_nxt             = 1'b1;
          push                = 1'b1;
          push_item.is_err    = 1'b1;
          push_item.row_end   = 1'b0;
          push_item.image_end = 1'b0;
        end else begin
          filt_nxt   = in_raw_byte[2:0];
          expect_nxt = 1'b0;
          col_nxt    = '0;
        end
      end else begin
        push = 1'b1;
        if (row_end) begin
          expect_nxt = 1'b1;
          col_nxt    = '0;
          row_nxt    = image_end ? '0 : (row_r + psu_pkg::ROW_W'(1));
        end else begin
          col_nxt = CW'(col_cl + ONE_EXT);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      filt_r   <= psu_pkg::FLT_NONE;
      expect_r <= 1'b1;
      err_r    <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      filt_r   <= filt_nxt;
      expect_r <= expect_nxt;
      err_r    <= err_nxt;
    end
  end

  assign stat.push = push;
  assign stat.err  = err_r;

endmodule

// ===== rtl/psu_fifo.sv =====
// short queue of classified bytes between front and back end
module psu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psu_pkg::item_t      push_item,
  input  logic                pop,
  output psu_pkg::item_t      head,
  output psu_pkg::fifo_stat_t stat
);

  psu_pkg::item_t                   q_r [psu_pkg::FIFO_DEPTH];
  logic [psu_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [psu_pkg::FIFO_CNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + psu_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + psu_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + psu_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - psu_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign stat.full  = cnt_r == psu_pkg::FIFO_CNT_W'(psu_pkg::FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;

endmodule

// ===== rtl/psu_back.sv =====
// back end: line store, neighbor history, filter reconstruction and output register
module psu_back #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psu_pkg::item_t      head,
  input  psu_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_pixel_byte,
  output logic                out_row_end,
  output logic                out_image_end,
  output logic                out_bad_filter
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  logic [7:0]     line_mem [MAX_ROW_BYTES];
  logic [7:0]     up_mem_r, last_r;
  logic           fwd_r;
  logic           x_valid_r;
  psu_pkg::item_t x_r;
  logic [7:0]     lh_r [psu_pkg::MAX_BPP];
  logic [7:0]     uh_r [psu_pkg::MAX_BPP];

  logic           out_valid_r, out_row_end_r, out_image_end_r, out_bad_r;
  logic [7:0]     out_pixel_r;

  logic           x_adv, wr_en;
  logic [7:0]     left, up, ul, pred, result;
  logic [8:0]     avg_sum;

  assign x_adv = x_valid_r && (!out_valid_r || !out_stall);
  assign pop   = !fifo_stat.empty && (!x_valid_r || x_adv);
  assign wr_en = x_adv && !x_r.is_err;

  // read lands with the item; the byte leaving this cycle is forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[x_r.col[CW-1:0]] <= result;
    end
    if (pop) begin
      up_mem_r <= line_mem[head.col[CW-1:0]];
    end
    if (wr_en) begin
      last_r <= result;
    end
    if (pop) begin
      x_r <= head;
    end
  end

  always_comb begin
    left    = x_r.left_ok ? lh_r[x_r.slot] : 8'd0;
    up      = x_r.row_nz ? (fwd_r ? last_r : up_mem_r) : 8'd0;
    ul      = (x_r.left_ok && x_r.row_nz) ? uh_r[x_r.slot] : 8'd0;
    avg_sum = {1'b0, left} + {1'b0, up};
    unique case (x_r.filter)
      psu_pkg::FLT_SUB:   pred = left;
      psu_pkg::FLT_UP:    pred = up;
      psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(left, up, ul);
      default:            pred = 8'd0;
    endcase
    result = x_r.raw + pred;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
      for (int i = 0; i < psu_pkg::MAX_BPP; i++) begin
        lh_r[i] <= '0;
        uh_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        x_valid_r <= 1'b1;
        fwd_r     <= wr_en && (x_r.col == head.col);
      end else if (x_adv) begin
        x_valid_r <= 1'b0;
      end
      if (wr_en) begin
        lh_r[x_r.slot] <= result;
        uh_r[x_r.slot] <= up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (x_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_adv) begin
      out_pixel_r     <= x_r.is_err ? 8'd0 : result;
      out_row_end_r   <= x_r.row_end;
      out_image_end_r <= x_r.image_end;
      out_bad_r       <= x_r.is_err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_pixel_r;
  assign out_row_end    = out_row_end_r;
  assign out_image_end  = out_image_end_r;
  assign out_bad_filter = out_bad_r;

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// PNG scanline filter reconstruction, one filtered byte in, one rebuilt byte out.
// The block takes one stream byte per cycle while the queue has room: a filter-type
// byte is absorbed without a result, every other byte gives its result after it
// passes the queue, the line-store read and the output register.
// Throughput is set by the reconstruct stage of the back end, where each byte's
// left neighbor is the result of the byte just before it, and by the line store,
// which is read once and written once per cycle. A four-entry queue between the
// classifying front end and the back end lets the input keep flowing while the
// output stalls briefly. The line store holds MAX_ROW_BYTES bytes and needs no
// clearing after reset. A filter type above four gives one result with
// bad_filter set; all later input is taken and dropped until reset.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_raw_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_pixel_byte,
  output logic                           out_row_end,
  output logic                           out_image_end,
  output logic                           out_bad_filter,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);

  psu_pkg::item_t       push_item, head;
  psu_pkg::front_stat_t front_stat;
  psu_pkg::fifo_stat_t  fifo_stat;
  logic                 pop;

  psu_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_byte (in_raw_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fifo_stat   (fifo_stat),
    .push_item   (push_item),
    .stat        (front_stat)
  );

  psu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_stat.push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  psu_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .fifo_stat      (fifo_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .out_bad_filter (out_bad_filter)
  );

`include "png_scanline_unfilter_assert.svh"

  // nothing is pushed into a full queue
  `PSU_ASSERT_NOW(a_no_push_when_full, front_stat.push, !fifo_stat.full)
  // an error result is the last result until reset
  `PSU_ASSERT_NEXT(a_error_is_last, out_valid && out_bad_filter, !out_valid || out_bad_filter)
  // once latched, the error stays and nothing more is queued
  `PSU_ASSERT_NEXT(a_error_sticky, front_stat.err, front_stat.err && !front_stat.push)

endmodule
